// ===== rtl/core/flpe_pkg.sv =====
`default_nettype none
package flpe_pkg;
  localparam int unsigned MaxOrder = 64;
  localparam int unsigned OrdW = 7;
  localparam int unsigned IdxW = $clog2(MaxOrder);

  typedef enum logic [3:0] {
    OpLoad,
    OpAp,
    OpS,
    OpP2Hi,
    OpP2,
    OpU2Hi,
    OpU2,
    OpLeftHi,
    OpLeft,
    OpRightHi,
    OpRight,
    OpValue,
    OpAdvance
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } dp_cmd_t;

  typedef logic [MaxOrder-1:0][32:0] recip_tab_t;

  // round(2^32 / (n+2)) for every order, evaluated at elaboration only
  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    logic [33:0] d, num, rem, quo;
    tab = '0;
    for (int i = 0; i < int'(MaxOrder); i++) begin
      d = 34'(i) + 34'd2;
      num = 34'h1_0000_0000 + (d >> 1);
      rem = '0;
      quo = '0;
      for (int b = 0; b < 34; b++) begin
        rem = {rem[32:0], num[33]};
        num = num << 1;
        quo = quo << 1;
        if (rem >= d) begin
          rem = rem - d;
          quo[0] = 1'b1;
        end
      end
      tab = {quo[32:0], tab[MaxOrder-1:1]};
    end
    return tab;
  endfunction

  localparam recip_tab_t RecipTab = build_recip();
endpackage
`default_nettype wire

// ===== rtl/core/flpe_datapath.sv =====
`default_nettype none
module flpe_datapath
  import flpe_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire dp_cmd_t                cmd_i,
  input  wire logic signed [31:0]     alpha_i,
  input  wire logic signed [31:0]     beta_i,
  input  wire logic [IdxW-1:0]        n_i,
  output logic signed [47:0]          value_o
);
  logic signed [31:0] alpha_q, beta_q, pp_q, pc_q, p2_q;
  logic signed [39:0] up_q, uc_q, u2_q;
  logic signed [47:0] ap_q, s_q, left_q, right_q, value_q;

  // wide products run in two passes: high half of x times y, then low half added
  logic signed [33:0] rcp;
  logic signed [63:0] m_a;
  logic signed [47:0] dif, rdif, mx;
  logic signed [33:0] my;
  logic signed [31:0] mx_hi;
  logic signed [16:0] mx_lo;
  logic signed [65:0] pp_hi, prod_q;
  logic signed [50:0] pp_lo;
  logic signed [95:0] full, u2_sum;
  logic signed [95:0] sum;

  always_comb begin
    rcp = {1'b0, RecipTab[n_i]};
    m_a = 64'(pc_q) * 64'(alpha_q);
    dif = 48'(pp_q) - ap_q;
    rdif = 48'(u2_q) - 48'(p2_q) - 48'(p2_q);
    unique case (cmd_i.op) inside
      OpP2Hi, OpP2: begin
        mx = s_q; my = rcp;
      end
      OpU2Hi, OpU2: begin
        mx = 48'(uc_q); my = 34'(alpha_q);
      end
      OpLeftHi, OpLeft: begin
        mx = dif; my = rcp;
      end
      OpRightHi, OpRight: begin
        mx = rdif; my = 34'(beta_q);
      end
      default: begin
        mx = '0; my = '0;
      end
    endcase
    mx_hi = 32'(mx >>> 16);
    mx_lo = {1'b0, mx[15:0]};
    pp_hi = 66'(mx_hi) * 66'(my);
    pp_lo = 51'(mx_lo) * 51'(my);
    full = (96'(prod_q) <<< 16) + 96'(pp_lo);
    u2_sum = (full >>> 29) - 96'(up_q);
    sum = 96'(left_q) - 96'(right_q);
  end

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'sh7fff_ffff;
    if (v < -96'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid) begin
      unique case (cmd_i.op) inside
        OpLoad: begin
          alpha_q <= alpha_i; beta_q <= beta_i;
          pp_q <= 32'sh4000_0000; pc_q <= alpha_i;
          up_q <= 40'sh00_4000_0000; uc_q <= 40'(alpha_i) <<< 1;
        end
        OpAp:    ap_q <= 48'(m_a >>> 30);
        OpS:     s_q <= 48'(ap_q * 48'(2 * n_i + 3)) - 48'(pp_q) * 48'(n_i + 1);
        OpP2Hi, OpU2Hi, OpLeftHi, OpRightHi: prod_q <= pp_hi;
        OpP2:    p2_q <= sat32(full >>> 32);
        OpU2: begin
          if (u2_sum > 96'sh7f_ffff_ffff) u2_q <= 40'sh7f_ffff_ffff;
          else if (u2_sum < -96'sh80_0000_0000) u2_q <= 40'sh80_0000_0000;
          else u2_q <= u2_sum[39:0];
        end
        OpLeft:  left_q <= 48'(full >>> 38);
        OpRight: right_q <= 48'(full >>> 30);
        OpValue: begin
          if (sum > 96'sh7fff_ffff_ffff) value_q <= 48'sh7fff_ffff_ffff;
          else if (sum < -96'sh8000_0000_0000) value_q <= 48'sh8000_0000_0000;
          else value_q <= sum[47:0];
        end
        OpAdvance: begin
          pp_q <= pc_q; pc_q <= p2_q; up_q <= uc_q; uc_q <= u2_q;
        end
        default: ;
      endcase
    end
  end
  assign value_o = value_q;
endmodule
`default_nettype wire

// ===== rtl/core/fresnel_legendre_poly_eval.sv =====
`default_nettype none
// Fresnel-Legendre evaluator: one input item (alpha, beta, count) yields count
// result items L_0..L_{count-1}, last set on the final one; count zero yields
// none, counts above 64 are cut to 64. Each order takes eleven sequencer
// steps on the shared datapath (each wide product split into two half-width
// passes) plus an Emit state holding the result. A result waits in the
// output register under stall; in_stall_o holds off a new item until the
// last result of the current one has been taken.
module fresnel_legendre_poly_eval
  import flpe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] alpha_i,
  input  wire logic signed [31:0] beta_i,
  input  wire logic [6:0]         count_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [47:0]      value_o,
  output logic [5:0]              order_o,
  output logic                    last_o
);
  typedef enum logic [1:0] {Idle, Run, Emit} state_e;
  state_e state_q;
  op_e op_q;
  logic [IdxW-1:0] n_q;
  logic [OrdW-1:0] left_q;
  dp_cmd_t cmd;
  logic acc;

  assign in_stall_o = (state_q != Idle);
  assign acc = in_valid_i && !in_stall_o && count_i != 7'd0;
  assign out_valid_o = (state_q == Emit);

  always_comb begin
    cmd.valid = acc || state_q == Run || (state_q == Emit && !out_stall_i);
    cmd.op = acc ? OpLoad : (state_q == Emit ? OpAdvance : op_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; op_q <= OpAp; n_q <= '0; left_q <= '0;
    end else begin
      unique case (state_q)
        Idle: if (acc) begin
          state_q <= Run; op_q <= OpAp; n_q <= '0;
          left_q <= (count_i > 7'(MaxOrder)) ? 7'(MaxOrder) : count_i;
        end
        Run: begin
          if (op_q == OpValue) state_q <= Emit;
          else op_q <= op_e'(op_q + 4'd1);
        end
        Emit: if (!out_stall_i) begin
          n_q <= n_q + IdxW'(1); left_q <= left_q - 7'd1; op_q <= OpAp;
          state_q <= (left_q == 7'd1) ? Idle : Run;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  flpe_datapath u_dp (
    .clk_i, .cmd_i(cmd), .alpha_i, .beta_i, .n_i(n_q), .value_o
  );
  assign order_o = n_q;
  assign last_o = (left_q == 7'd1);

  a_emit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_q != 7'd0) else $error("emit with nothing left");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o))
    else $error("result lost");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != Idle |-> in_stall_o) else $error("accepted while busy");
endmodule
`default_nettype wire
